// ===== design/gbc_pkg.sv =====
package gbc_pkg;

    localparam int SAMPLES_LOG2 = 8;
    localparam int CNT_W        = SAMPLES_LOG2 + 1;
    localparam int AXES         = 3;
    localparam int AXIS_W       = 16;
    localparam int SUM_W        = 24;
    localparam int THR_W        = 15;
    localparam int STIME_W      = 16;
    localparam int TIME_W       = 32;
    localparam int CFG_DATA_W   = 16;

    localparam logic [THR_W-1:0]   THR_RESET   = 15'd512;
    localparam logic [STIME_W-1:0] STIME_RESET = 16'd1000;

    // number of samples averaged per calibration
    localparam logic [CNT_W-1:0] SAMPLES = CNT_W'(2 ** SAMPLES_LOG2);

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_WAIT   = 2'd1,
        PH_SAMPLE = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_START  = 2'd1,
        KIND_CANCEL = 2'd2,
        KIND_LOAD   = 2'd3
    } kind_t;

    typedef enum logic {
        REG_THRESHOLD = 1'b0,
        REG_STIME     = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic clear;
        logic accumulate;
        logic finish;
        logic load;
    } lane_ctl_t;

    typedef struct packed {
        logic [AXES-1:0][AXIS_W-1:0] val;
        logic                        corrected_valid;
        logic                        calibration_done;
        logic [1:0]                  phase;
    } result_t;

endpackage

// ===== design/gbc_lane.sv =====
module gbc_lane
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  gbc_pkg::lane_ctl_t                  ctl,
    input  logic signed [gbc_pkg::AXIS_W-1:0]   sample,
    input  logic [gbc_pkg::THR_W-1:0]           threshold,
    output logic                                still,
    output logic signed [gbc_pkg::AXIS_W-1:0]   corrected,
    output logic signed [gbc_pkg::AXIS_W-1:0]   new_offset
);

    localparam int SW = gbc_pkg::SUM_W;
    localparam int AW = gbc_pkg::AXIS_W;
    localparam logic signed [SW:0] HALF = (SW+1)'((2 ** gbc_pkg::SAMPLES_LOG2) / 2);
    localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [SW:0] OUT_MAX = (SW+1)'(2 ** (AW-1) - 1);
    localparam logic signed [SW:0] OUT_MIN = -OUT_MAX - (SW+1)'(1);
    localparam logic signed [AW:0] DIFF_MAX = (AW+1)'(2 ** (AW-1) - 1);
    localparam logic signed [AW:0] DIFF_MIN = -DIFF_MAX - (AW+1)'(1);

    logic signed [SW-1:0] sum_reg;
    logic signed [SW-1:0] sum_next;
    logic signed [AW-1:0] offset_reg;
    logic signed [AW-1:0] offset_next;

    logic signed [SW:0]   sum_add;
    logic signed [SW-1:0] sum_sat;
    logic signed [SW:0]   rnd;
    logic signed [SW:0]   quot;
    logic signed [AW:0]   diff;
    logic [AW:0]          mag;

    always_comb
    begin
        // stillness check, magnitude of the most negative value fits in 17 bits
        mag   = sample[AW-1] ? (AW+1)'(-(AW+1)'(sample)) : (AW+1)'(sample);
        still = mag < (AW+1)'(threshold);

        diff = (AW+1)'(sample) - (AW+1)'(offset_reg);
        if (diff > DIFF_MAX)
            corrected = AW'(DIFF_MAX);
        else if (diff < DIFF_MIN)
            corrected = AW'(DIFF_MIN);
        else
            corrected = AW'(diff);

        sum_add = (SW+1)'(sum_reg) + (SW+1)'(sample);
        if (sum_add[SW] != sum_add[SW-1])
            sum_sat = sum_add[SW] ? SUM_MIN : SUM_MAX;
        else
            sum_sat = SW'(sum_add);

        // round to nearest, ties upward
        rnd  = (SW+1)'(sum_sat) + HALF;
        quot = rnd >>> gbc_pkg::SAMPLES_LOG2;
        if (quot > OUT_MAX)
            new_offset = AW'(OUT_MAX);
        else if (quot < OUT_MIN)
            new_offset = AW'(OUT_MIN);
        else
            new_offset = AW'(quot);

        sum_next    = sum_reg;
        offset_next = offset_reg;
        if (accept)
        begin
            if (ctl.clear)
                sum_next = '0;
            else if (ctl.accumulate)
                sum_next = sum_sat;
            if (ctl.load)
                offset_next = sample;
            else if (ctl.finish)
                offset_next = new_offset;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            offset_reg <= '0;
        end
        else
        begin
            sum_reg    <= sum_next;
            offset_reg <= offset_next;
        end
    end

endmodule

// ===== design/gbc_ctrl.sv =====
module gbc_ctrl
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [1:0]                      kind,
    input  logic [gbc_pkg::TIME_W-1:0]      time_ms,
    input  logic                            still_all,
    input  logic [gbc_pkg::STIME_W-1:0]     stime,
    output gbc_pkg::lane_ctl_t              ctl,
    output gbc_pkg::phase_t                 phase_next,
    output logic                            corrected_valid,
    output logic                            calibration_done
);

    gbc_pkg::phase_t                 phase_reg;
    logic                            timer_valid_reg;
    logic                            timer_valid_next;
    logic [gbc_pkg::TIME_W-1:0]      start_ms_reg;
    logic [gbc_pkg::TIME_W-1:0]      start_ms_next;
    logic [gbc_pkg::CNT_W-1:0]       count_reg;
    logic [gbc_pkg::CNT_W-1:0]       count_next;
    logic [gbc_pkg::CNT_W-1:0]       count_inc;
    logic [gbc_pkg::TIME_W-1:0]      elapsed;

    always_comb
    begin
        phase_next       = phase_reg;
        timer_valid_next = timer_valid_reg;
        start_ms_next    = start_ms_reg;
        count_next       = count_reg;
        ctl              = '0;
        corrected_valid  = 1'b0;
        calibration_done = 1'b0;
        count_inc        = count_reg + 1'b1;
        elapsed          = time_ms - start_ms_reg;

        case (gbc_pkg::kind_t'(kind))
            gbc_pkg::KIND_START, gbc_pkg::KIND_CANCEL:
            begin
                phase_next = (gbc_pkg::kind_t'(kind) == gbc_pkg::KIND_START)
                           ? gbc_pkg::PH_WAIT : gbc_pkg::PH_IDLE;
                timer_valid_next = 1'b0;
                start_ms_next    = '0;
                count_next       = '0;
                ctl.clear        = 1'b1;
            end
            gbc_pkg::KIND_LOAD:
            begin
                ctl.load = 1'b1;
            end
            default:
            begin
                case (phase_reg)
                    gbc_pkg::PH_WAIT:
                    begin
                        if (!still_all)
                            timer_valid_next = 1'b0;
                        else if (!timer_valid_reg)
                        begin
                            timer_valid_next = 1'b1;
                            start_ms_next    = time_ms;
                        end
                        else if (elapsed >= gbc_pkg::TIME_W'(stime))
                        begin
                            phase_next = gbc_pkg::PH_SAMPLE;
                            count_next = '0;
                            ctl.clear  = 1'b1;
                        end
                    end
                    gbc_pkg::PH_SAMPLE:
                    begin
                        ctl.accumulate = 1'b1;
                        count_next     = count_inc;
                        if (count_inc == gbc_pkg::SAMPLES)
                        begin
                            // final sample: store the average and drop back to idle
                            ctl.finish       = 1'b1;
                            ctl.clear        = 1'b1;
                            calibration_done = 1'b1;
                            phase_next       = gbc_pkg::PH_IDLE;
                            timer_valid_next = 1'b0;
                            start_ms_next    = '0;
                            count_next       = '0;
                        end
                    end
                    default:
                    begin
                        phase_next      = gbc_pkg::PH_IDLE;
                        corrected_valid = 1'b1;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= gbc_pkg::PH_IDLE;
            timer_valid_reg <= 1'b0;
            start_ms_reg    <= '0;
            count_reg       <= '0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            timer_valid_reg <= timer_valid_next;
            start_ms_reg    <= start_ms_next;
            count_reg       <= count_next;
        end
    end

endmodule

// ===== design/gbc_out.sv =====
module gbc_out
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  gbc_pkg::result_t    data,
    output logic                push_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output gbc_pkg::result_t    out_data
);

    logic               out_valid_reg;
    logic               skid_valid_reg;
    gbc_pkg::result_t   out_reg;
    gbc_pkg::result_t   skid_reg;
    logic               out_load;

    assign out_load   = !out_valid_reg || out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= skid_valid_reg || push;
            // skid holds a transfer that arrives while the output register is stalled
            if (skid_valid_reg && out_load)
                skid_valid_reg <= 1'b0;
            else if (push && !out_load)
                skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (push)
                out_reg <= data;
        end
        if (push && !out_load)
            skid_reg <= data;
    end

endmodule

// ===== design/gyro_bias_calibrator.sv =====
// Gyro zero-rate bias calibrator. Each transfer on the sample channel is a gyro sample or a
// start, cancel or load-offset command; each yields exactly one transfer on the result channel.
// One item is taken every clock cycle while sample_ready is high: the three axes are handled by
// three identical lanes (subtract and saturate, stillness compare, 24-bit accumulate, rounded
// average) and a small controller takes their ANDed stillness flags and steps the phase, timer
// and sample counter, all within the cycle of acceptance. The result is registered, and
// a two-entry output buffer lets a further item in while a result waits on result_ready.
// Calibration averages 2^SAMPLES_LOG2 samples after the stillness time has run out.
// Configuration writes (index 0 threshold, index 1 stillness time) are always ready.
module gyro_bias_calibrator
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  logic [1:0]                          kind,
    input  logic signed [gbc_pkg::AXIS_W-1:0]   axis_x,
    input  logic signed [gbc_pkg::AXIS_W-1:0]   axis_y,
    input  logic signed [gbc_pkg::AXIS_W-1:0]   axis_z,
    input  logic [gbc_pkg::TIME_W-1:0]          time_ms,

    output logic                                result_valid,
    input  logic                                result_ready,
    output logic signed [gbc_pkg::AXIS_W-1:0]   out_x,
    output logic signed [gbc_pkg::AXIS_W-1:0]   out_y,
    output logic signed [gbc_pkg::AXIS_W-1:0]   out_z,
    output logic                                corrected_valid,
    output logic                                calibration_done,
    output logic [1:0]                          phase,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [gbc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int AXES = gbc_pkg::AXES;
    localparam int AW   = gbc_pkg::AXIS_W;

    logic [gbc_pkg::THR_W-1:0]      threshold_reg;
    logic [gbc_pkg::STIME_W-1:0]    stime_reg;

    logic                           accept;
    logic [AXES-1:0][AW-1:0]        axis_in;
    logic [AXES-1:0]                still;
    logic [AXES-1:0][AW-1:0]        corrected;
    logic [AXES-1:0][AW-1:0]        new_offset;
    gbc_pkg::lane_ctl_t             ctl;
    gbc_pkg::phase_t                phase_next;
    logic                           cvalid;
    logic                           done;
    gbc_pkg::result_t               result;
    gbc_pkg::result_t               result_q;

    assign cfg_ready = 1'b1;
    assign accept    = sample_valid && sample_ready;
    assign axis_in   = {axis_z, axis_y, axis_x};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= gbc_pkg::THR_RESET;
            stime_reg     <= gbc_pkg::STIME_RESET;
        end
        else if (cfg_valid)
        begin
            case (gbc_pkg::cfg_reg_t'(cfg_index))
                gbc_pkg::REG_THRESHOLD: threshold_reg <= cfg_data[gbc_pkg::THR_W-1:0];
                gbc_pkg::REG_STIME:     stime_reg     <= cfg_data[gbc_pkg::STIME_W-1:0];
                default:                threshold_reg <= threshold_reg;
            endcase
        end
    end

    for (genvar i = 0; i < AXES; i++)
    begin : g_lane
        gbc_lane u_lane
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .accept     (accept),
            .ctl        (ctl),
            .sample     (axis_in[i]),
            .threshold  (threshold_reg),
            .still      (still[i]),
            .corrected  (corrected[i]),
            .new_offset (new_offset[i])
        );
    end

    gbc_ctrl u_ctrl
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .kind             (kind),
        .time_ms          (time_ms),
        .still_all        (&still),
        .stime            (stime_reg),
        .ctl              (ctl),
        .phase_next       (phase_next),
        .corrected_valid  (cvalid),
        .calibration_done (done)
    );

    always_comb
    begin
        if (cvalid)
            result.val = corrected;
        else if (done)
            result.val = new_offset;
        else
            result.val = '0;
        result.corrected_valid  = cvalid;
        result.calibration_done = done;
        result.phase            = phase_next;
    end

    gbc_out u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .data       (result),
        .push_ready (sample_ready),
        .out_valid  (result_valid),
        .out_ready  (result_ready),
        .out_data   (result_q)
    );

    assign out_x            = result_q.val[0];
    assign out_y            = result_q.val[1];
    assign out_z            = result_q.val[2];
    assign corrected_valid  = result_q.corrected_valid;
    assign calibration_done = result_q.calibration_done;
    assign phase            = result_q.phase;

endmodule
